/* rtl/mexp_pkg.sv */
// Shared constants, types and controller/datapath interface structs for the exponentiator.
`default_nettype none

package mexp_pkg;

  localparam int WORD_BITS = 16;
  localparam int IDX_W     = $clog2(WORD_BITS);
  localparam int CFG_IDX_W = 2;

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [2*WORD_BITS-1:0] dword_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

  localparam cfg_idx_t REG_MODULUS  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_EXPONENT = cfg_idx_t'(1);

  typedef struct packed {
    logic load;
    logic mul;
    logic sq;
    logic red;
    logic red_last;
    idx_t step;
    idx_t bit_idx;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_bit;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/modular_exponentiation.sv */
// Top level of the modular exponentiator: controller and datapath.
//
//   channel   direction  handshake                  payload
//   symbol    in         symbol_valid/symbol_ready  symbol
//   result    out        result_valid/result_ready  result_symbol
//   cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// An item holds the block from its transfer until its result is loaded into the output
// register; a zero exponent skips the multiplications and gives a result of 1.
// Each modular multiplication is a multiplier step followed by a serial reduction of the
// product, two remainder bits per cycle.
// A new symbol is taken while the previous result still waits in the output register.
// Reset sets modulus and exponent to 1 and empties the output register.
// Configuration writes are always taken and must be made only while the block is idle.
`default_nettype none

module modular_exponentiation (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               symbol_valid,
  output logic                    symbol_ready,
  input  wire mexp_pkg::word_t    symbol,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output mexp_pkg::word_t         result_symbol,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire mexp_pkg::cfg_idx_t cfg_index,
  input  wire mexp_pkg::word_t    cfg_data
);
  import mexp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  mexp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .symbol_valid (symbol_valid),
    .symbol_ready (symbol_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  mexp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .symbol        (symbol),
    .cmd           (cmd),
    .stat          (stat),
    .result_symbol (result_symbol)
  );

endmodule

`default_nettype wire

/* rtl/mexp_ctrl.sv */
// Controller state machine sequencing square-and-multiply and the serial reductions.
`default_nettype none

module mexp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               symbol_valid,
  output logic                    symbol_ready,
  output logic                    result_valid,
  input  wire logic               result_ready,
  input  wire mexp_pkg::dp_stat_t stat,
  output mexp_pkg::dp_cmd_t       cmd
);
  import mexp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_RED  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  localparam idx_t STEP_LAST = idx_t'(WORD_BITS - 1);
  localparam idx_t BIT_TOP   = idx_t'(WORD_BITS - 1);

  state_t state, state_next;
  idx_t   bit_idx, bit_idx_next;
  idx_t   step, step_next;
  logic   sq, sq_next;
  logic   result_valid_next;

  always_comb begin
    state_next        = state;
    bit_idx_next      = bit_idx;
    step_next         = step;
    sq_next           = sq;
    result_valid_next = result_valid;
    cmd               = '0;
    cmd.step          = step;
    cmd.bit_idx       = bit_idx;
    cmd.sq            = sq;
    if (result_valid && result_ready) begin
      result_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (symbol_valid) begin
          cmd.load     = 1'b1;
          bit_idx_next = BIT_TOP;
          sq_next      = 1'b1;
          state_next   = stat.exp_zero ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        step_next  = '0;
        state_next = S_RED;
      end
      S_RED: begin
        cmd.red   = 1'b1;
        step_next = step + 1'b1;
        if (step == STEP_LAST) begin
          cmd.red_last = 1'b1;
          if (sq && stat.exp_bit) begin
            sq_next    = 1'b0;
            state_next = S_MUL;
          end else if (bit_idx == '0) begin
            state_next = S_FIN;
          end else begin
            bit_idx_next = bit_idx - 1'b1;
            sq_next      = 1'b1;
            state_next   = S_MUL;
          end
        end
      end
      S_FIN: begin
        if (!result_valid || result_ready) begin
          cmd.load_out      = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign symbol_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      bit_idx      <= '0;
      step         <= '0;
      sq           <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      bit_idx      <= bit_idx_next;
      step         <= step_next;
      sq           <= sq_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/mexp_dp.sv */
// Datapath: key registers, multiplier, two-bit-per-cycle restoring reduction and result register.
`default_nettype none

module mexp_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  input  wire mexp_pkg::cfg_idx_t cfg_index,
  input  wire mexp_pkg::word_t    cfg_data,
  input  wire mexp_pkg::word_t    symbol,
  input  wire mexp_pkg::dp_cmd_t  cmd,
  output mexp_pkg::dp_stat_t      stat,
  output mexp_pkg::word_t         result_symbol
);
  import mexp_pkg::*;

  word_t  modulus;
  word_t  exponent;
  word_t  base;
  word_t  acc;
  word_t  remainder;
  dword_t prod;

  word_t                mul_opb;
  dword_t               prod_next;
  logic [1:0]           pair;
  logic [WORD_BITS:0]   m_ext;
  logic [WORD_BITS:0]   t1, r1, t2, r2;
  word_t                acc_red;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= word_t'(1);
      exponent <= word_t'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODULUS:  modulus  <= cfg_data;
        REG_EXPONENT: exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_opb   = cmd.sq ? acc : base;
    prod_next = dword_t'(acc) * dword_t'(mul_opb);
    pair      = prod[(2*WORD_BITS-1) - 2*int'(cmd.step) -: 2];
    m_ext     = {1'b0, modulus};
    t1        = {remainder, pair[1]};
    r1        = (t1 >= m_ext) ? (t1 - m_ext) : t1;
    t2        = {r1[WORD_BITS-1:0], pair[0]};
    r2        = (t2 >= m_ext) ? (t2 - m_ext) : t2;
    acc_red   = (modulus == '0) ? prod[WORD_BITS-1:0] : r2[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base <= symbol;
      acc  <= word_t'(1);
    end
    if (cmd.mul) begin
      prod      <= prod_next;
      remainder <= '0;
    end
    if (cmd.red) begin
      remainder <= r2[WORD_BITS-1:0];
      if (cmd.red_last) begin
        acc <= acc_red;
      end
    end
    if (cmd.load_out) begin
      result_symbol <= acc;
    end
  end

  assign stat.exp_zero = (exponent == '0);
  assign stat.exp_bit  = exponent[cmd.bit_idx];

endmodule

`default_nettype wire

/* rtl/mexp_checker.sv */
// Port-level checker for the modular exponentiator and its bind to the top level.
`default_nettype none

module mexp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               symbol_valid,
  input wire logic               symbol_ready,
  input wire logic               result_valid,
  input wire logic               result_ready,
  input wire mexp_pkg::word_t    result_symbol,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready
);
  import mexp_pkg::*;

  // A result waiting for transfer keeps its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_symbol))
    else $error("result changed while stalled");

  // Only one symbol is in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    symbol_valid && symbol_ready |=> !symbol_ready)
    else $error("second symbol taken during computation");

  // No result can appear in the cycle right after a symbol transfer.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    symbol_valid && symbol_ready |=> !$rose(result_valid))
    else $error("result appeared too early");

  // The configuration port never stalls.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration port stalled");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

`default_nettype wire
